FILE: hw/rtl/abud_pkg.sv
`timescale 1ns / 1ps

package abud_pkg;

	localparam int MAX_ALPHABET_DEF = 32;
	localparam int CHAR_W           = 8;
	localparam int CNT_W            = 6;   // alphabet size, used count, field bit count
	localparam int LEN_W            = 32;
	localparam int ACC_W            = 5;   // widest code
	localparam int CWID_W           = 3;
	localparam int CFG_REGS         = 4;   // character registers
	localparam int CFG_DATA_W       = 64;
	localparam int CFG_IDX_W        = 3;
	localparam int ALPHA_W          = CFG_REGS * CFG_DATA_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_0       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_1       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_2       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_3       = 3'd4;

	// length type codes
	localparam logic [1:0] LK_8    = 2'd0;
	localparam logic [1:0] LK_16   = 2'd1;
	localparam logic [1:0] LK_32   = 2'd2;
	localparam logic [1:0] LK_NONE = 2'd3;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LEN,
		PH_MASK,
		PH_CODE,
		PH_PAD
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIT,
		ST_BUILD,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
	} build_stat_t;

	function automatic logic [CWID_W-1:0] width_for(input logic [CNT_W-1:0] n);
		logic [CWID_W-1:0] w;
		if (n <= 6'd2) begin
			w = 3'd1;
		end else if (n <= 6'd4) begin
			w = 3'd2;
		end else if (n <= 6'd8) begin
			w = 3'd3;
		end else if (n <= 6'd16) begin
			w = 3'd4;
		end else begin
			w = 3'd5;
		end
		return w;
	endfunction

endpackage

FILE: hw/rtl/alphabet_bit_unpack_decoder.sv
// A byte is taken in the idle state; its 8 stream bits are then handled one per cycle,
// pausing for build and emit. Completing the used mask adds one build pass over the
// effective entries. Each decoded character adds an emit state for the table read, held
// while the output stalls. A new byte is taken only in idle; output register decouples sides.
// Reset (arst_n low, asynchronous): parser at length type, config at defaults, output empty.
// The symbol table has no reset and needs no clearing pass.
`timescale 1ns / 1ps

module alphabet_bit_unpack_decoder #(
	parameter int MAX_ALPHABET = abud_pkg::MAX_ALPHABET_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [abud_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [abud_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         data_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [abud_pkg::CHAR_W-1:0]        out_char,
	output logic                               code_invalid,
	output logic                               last
);
	import abud_pkg::*;

	localparam int AW = $clog2(MAX_ALPHABET);

	// configuration registers
	logic [CNT_W-1:0]      alphabet_size_q;
	logic [CFG_DATA_W-1:0] chars_q [CFG_REGS];

	logic [CNT_W-1:0]        eff_size;
	logic [ALPHA_W-1:0]      alpha;
	logic                    build_start;
	build_stat_t             build_stat;
	logic [MAX_ALPHABET-1:0] used_mask;
	logic                    wr_en, rd_en;
	logic [AW-1:0]           wr_addr, rd_addr;
	logic [CHAR_W-1:0]       wr_data, rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_size_q <= 6'd4;
			for (int i = 0; i < CFG_REGS; i++) begin
				chars_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALPHABET_SIZE: alphabet_size_q <= cfg_data[CNT_W-1:0];
				CFG_CHARS_0:       chars_q[0] <= cfg_data;
				CFG_CHARS_1:       chars_q[1] <= cfg_data;
				CFG_CHARS_2:       chars_q[2] <= cfg_data;
				CFG_CHARS_3:       chars_q[3] <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// zero acts as one entry, oversize clamps to the table depth
	always_comb begin
		if (alphabet_size_q == '0) begin
			eff_size = 6'd1;
		end else if (alphabet_size_q > CNT_W'(MAX_ALPHABET)) begin
			eff_size = CNT_W'(MAX_ALPHABET);
		end else begin
			eff_size = alphabet_size_q;
		end
	end

	// entry 0 in the low byte of the first character register
	assign alpha = {chars_q[3], chars_q[2], chars_q[1], chars_q[0]};

	// bit-serial parser, code decoder and output register
	abud_seq #(
		.MAX_ALPHABET(MAX_ALPHABET)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.code_invalid(code_invalid),
		.last        (last),
		.eff_size    (eff_size),
		.build_start (build_start),
		.build_stat  (build_stat),
		.used_mask   (used_mask),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	// walks the alphabet once per stream to fill the code table
	abud_build #(
		.MAX_ALPHABET(MAX_ALPHABET)
	) u_build (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (build_start),
		.eff_size (eff_size),
		.used_mask(used_mask),
		.alpha    (alpha),
		.stat     (build_stat),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// code-to-character table, registered read
	abud_symtab #(
		.MAX_ALPHABET(MAX_ALPHABET)
	) u_symtab (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

FILE: hw/rtl/abud_symtab.sv
`timescale 1ns / 1ps

module abud_symtab #(
	parameter int MAX_ALPHABET = abud_pkg::MAX_ALPHABET_DEF
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(MAX_ALPHABET)-1:0]   wr_addr,
	input  logic [abud_pkg::CHAR_W-1:0]       wr_data,
	input  logic                              rd_en,
	input  logic [$clog2(MAX_ALPHABET)-1:0]   rd_addr,
	output logic [abud_pkg::CHAR_W-1:0]       rd_data
);
	import abud_pkg::*;

	logic [CHAR_W-1:0] mem [MAX_ALPHABET];
	logic [CHAR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/abud_build.sv
`timescale 1ns / 1ps

module abud_build #(
	parameter int MAX_ALPHABET = abud_pkg::MAX_ALPHABET_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [abud_pkg::CNT_W-1:0]        eff_size,
	input  logic [MAX_ALPHABET-1:0]           used_mask,
	input  logic [abud_pkg::ALPHA_W-1:0]      alpha,
	output abud_pkg::build_stat_t             stat,
	output logic                              wr_en,
	output logic [$clog2(MAX_ALPHABET)-1:0]   wr_addr,
	output logic [abud_pkg::CHAR_W-1:0]       wr_data
);
	import abud_pkg::*;

	localparam int AW = $clog2(MAX_ALPHABET);

	logic             busy_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_inc;
	logic             hit;

	// one alphabet entry per cycle; used entries are packed into the table
	assign hit     = busy_q && used_mask[idx_q[AW-1:0]];
	assign idx_inc = idx_q + 6'd1;

	assign stat.done  = busy_q && (idx_inc >= eff_size);
	assign stat.count = cnt_q + CNT_W'(hit);

	assign wr_en   = hit;
	assign wr_addr = cnt_q[AW-1:0];
	assign wr_data = alpha[{idx_q[4:0], 3'b000} +: CHAR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !stat.done;
			idx_q  <= idx_inc;
			cnt_q  <= stat.count;
		end
	end

endmodule

FILE: hw/rtl/abud_seq.sv
`timescale 1ns / 1ps

module abud_seq #(
	parameter int MAX_ALPHABET = abud_pkg::MAX_ALPHABET_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [abud_pkg::CHAR_W-1:0]       out_char,
	output logic                              code_invalid,
	output logic                              last,
	input  logic [abud_pkg::CNT_W-1:0]        eff_size,
	output logic                              build_start,
	input  abud_pkg::build_stat_t             build_stat,
	output logic [MAX_ALPHABET-1:0]           used_mask,
	output logic                              rd_en,
	output logic [$clog2(MAX_ALPHABET)-1:0]   rd_addr,
	input  logic [abud_pkg::CHAR_W-1:0]       rd_data
);
	import abud_pkg::*;

	localparam int AW = $clog2(MAX_ALPHABET);

	ctl_state_t state_q, state_d;
	phase_t     phase_q, phase_d;

	logic [7:0]              byte_q;
	logic [2:0]              bit_idx_q;
	logic [CNT_W-1:0]        fbc_q, fbc_d, fbc_inc;
	logic [1:0]              lk_q, lk_d;
	logic [LEN_W-1:0]        rem_q, rem_d;
	logic [MAX_ALPHABET-1:0] mask_q, mask_d;
	logic [CNT_W-1:0]        ucount_q, ucount_d;
	logic [CWID_W-1:0]       cwidth_q, cwidth_d;
	logic [ACC_W-1:0]        accum_q, accum_d, code_c;
	logic                    bad_q, bad_d;
	logic                    lastc_q, lastc_d;
	logic [CNT_W-1:0]        need;
	logic                    b;
	logic                    to_build, to_emit, byte_end;
	logic                    out_valid_q, out_free, out_load;
	logic [CHAR_W-1:0]       out_char_q;
	logic                    code_invalid_q, last_q;

	assign b        = byte_q[bit_idx_q];
	assign fbc_inc  = fbc_q + 6'd1;
	assign code_c   = accum_q | (ACC_W'(b) << fbc_q[2:0]);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_EMIT) && out_free;

	always_comb begin
		unique case (lk_q)
			LK_8:    need = 6'd8;
			LK_16:   need = 6'd16;
			default: need = 6'd32;
		endcase
	end

	// stream bit datapath
	always_comb begin
		phase_d  = phase_q;
		fbc_d    = fbc_q;
		lk_d     = lk_q;
		rem_d    = rem_q;
		mask_d   = mask_q;
		ucount_d = ucount_q;
		cwidth_d = cwidth_q;
		accum_d  = accum_q;
		bad_d    = bad_q;
		lastc_d  = lastc_q;
		to_build = 1'b0;
		to_emit  = 1'b0;
		if (state_q == ST_BIT) begin
			unique case (phase_q)
				PH_TYPE: begin
					lk_d  = lk_q | (2'(b) << fbc_q[0]);
					fbc_d = fbc_inc;
					if (fbc_inc >= 6'd2) begin
						fbc_d   = '0;
						rem_d   = '0;
						mask_d  = '0;
						phase_d = (lk_d == LK_NONE) ? PH_MASK : PH_LEN;
					end
				end
				PH_LEN: begin
					rem_d = {rem_q[LEN_W-2:0], b};
					fbc_d = fbc_inc;
					if (fbc_inc >= need) begin
						fbc_d   = '0;
						phase_d = PH_MASK;
					end
				end
				PH_MASK: begin
					if (fbc_q < CNT_W'(MAX_ALPHABET)) begin
						mask_d[fbc_q[AW-1:0]] = b;
					end
					fbc_d = fbc_inc;
					if (fbc_inc >= eff_size) begin
						to_build = 1'b1;
					end
				end
				PH_CODE: begin
					accum_d = code_c;
					fbc_d   = fbc_inc;
					if (fbc_inc >= CNT_W'(cwidth_q)) begin
						to_emit = 1'b1;
						bad_d   = {1'b0, code_c} >= ucount_q;
						rem_d   = rem_q - 32'd1;
						lastc_d = (rem_d == '0);
						accum_d = '0;
						fbc_d   = '0;
						if (rem_d == '0) begin
							phase_d = PH_PAD;
						end
					end
				end
				default: ;
			endcase
		end
		if ((state_q == ST_BUILD) && build_stat.done) begin
			ucount_d = build_stat.count;
			cwidth_d = width_for(build_stat.count);
			accum_d  = '0;
			fbc_d    = '0;
			phase_d  = (rem_q == '0) ? PH_PAD : PH_CODE;
		end
		// bit index wraps to zero after bit 7, so zero in a side state means byte done
		byte_end = ((state_q == ST_BIT) && (bit_idx_q == 3'd7) && !to_build && !to_emit) ||
			((state_q == ST_BUILD) && build_stat.done && (bit_idx_q == 3'd0)) ||
			(out_load && (bit_idx_q == 3'd0));
		if (byte_end && (phase_d == PH_PAD)) begin
			phase_d = PH_TYPE;
			fbc_d   = '0;
			lk_d    = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_BIT;
				end
			end
			ST_BIT: begin
				if (to_build) begin
					state_d = ST_BUILD;
				end else if (to_emit) begin
					state_d = ST_EMIT;
				end else if (byte_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_BUILD: begin
				if (build_stat.done) begin
					state_d = byte_end ? ST_IDLE : ST_BIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = byte_end ? ST_IDLE : ST_BIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign build_start = to_build;
	assign used_mask   = mask_d;
	assign rd_en       = to_emit;
	assign rd_addr     = code_c[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_TYPE;
			bit_idx_q   <= '0;
			fbc_q       <= '0;
			lk_q        <= '0;
			rem_q       <= '0;
			mask_q      <= '0;
			ucount_q    <= '0;
			cwidth_q    <= 3'd1;
			accum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			fbc_q    <= fbc_d;
			lk_q     <= lk_d;
			rem_q    <= rem_d;
			mask_q   <= mask_d;
			ucount_q <= ucount_d;
			cwidth_q <= cwidth_d;
			accum_q  <= accum_d;
			if (state_q == ST_IDLE) begin
				bit_idx_q <= '0;
			end else if (state_q == ST_BIT) begin
				bit_idx_q <= bit_idx_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= data_byte;
		end
		bad_q   <= bad_d;
		lastc_q <= lastc_d;
		if (out_load) begin
			out_char_q     <= bad_q ? '0 : rd_data;
			code_invalid_q <= bad_q;
			last_q         <= lastc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign code_invalid = code_invalid_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	a_build_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUILD) |-> (phase_q == PH_MASK))
		else $error("table build outside mask phase");

	a_code_has_chars: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CODE) |-> (rem_q != '0))
		else $error("code phase with no characters left");

	a_emit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((phase_q == PH_CODE) || (phase_q == PH_PAD)))
		else $error("emit outside code phase");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("output loaded outside emit");
`endif

endmodule
